// File: design/cmbm_pkg.sv
`default_nettype none

package cmbm_pkg;

   // Field widths of the bus access and of its translation.
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int MODE_W     = 3;
   localparam int ROM_ADDR_W = 22;

   // Default PRG ROM address width, allowed range 15 to 22.
   localparam int PRG_ADDR_BITS_DEFAULT = 22;

   // Access kinds.
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Mapping modes held in the mode latch.
   localparam logic [MODE_W-1:0] MODE_32K_A     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_16K_SPLIT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_8K_A      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_16K_A     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_32K_B     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WRAM      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_8K_B      = 3'd6;
   localparam logic [MODE_W-1:0] MODE_16K_B     = 3'd7;

   // CPU address window boundaries.
   localparam logic [ADDR_W-1:0] WRAM_BASE  = 16'h6000;
   localparam logic [ADDR_W-1:0] ROM_BASE   = 16'h8000;
   localparam logic [ADDR_W-1:0] UPPER_BASE = 16'hC000;
   localparam logic [ADDR_W-1:0] LATCH_BASE = 16'hF000;

   // Bit of the bank byte that selects horizontal mirroring.
   localparam int MIRROR_BIT = 6;

   // Contents of the mode and bank latch.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] bank;
   } latch_state_type;

   // Translation of one CPU address.
   typedef struct packed {
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  selected;
   } map_result_type;

endpackage

`default_nettype wire

// File: design/cartridge_multimode_bank_mapper.sv
`default_nettype none

// Cartridge bank mapper for a multimode game cartridge.
// The request channel (req_) carries one bus access per item: its kind, the
// CPU address and the write data. A write to $F000-$FFFF loads address bits
// 2..0 as the mode and the data byte as the bank; other writes are ignored.
// The response channel (rsp_) returns one item per request: the PRG ROM
// address and select for the CPU address under the latch after this access,
// whether the write was taken, the pattern RAM write enable and mirroring.
// Items pass an input register and an output register. A request accepted
// into the input register moves on into the output register, which presents
// its response; one item is taken per cycle while the receiver does not stall.
// The latch is updated when the item moves into the output register.
// Reset is synchronous and empties both item registers and clears the latch to
// mode 0, bank 0. When the receiver stalls, the response holds, the item
// behind it waits in the input register, and req_stall rises only once that
// register is full; a single free register keeps the request side moving.
module cartridge_multimode_bank_mapper
   import cmbm_pkg::*;
#(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [ADDR_W-1:0]     req_cpu_address,
   input  wire logic [DATA_W-1:0]     req_write_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ROM_ADDR_W-1:0]      rsp_rom_address,
   output logic                       rsp_rom_selected,
   output logic                       rsp_write_taken,
   output logic                       rsp_chr_write_enable,
   output logic                       rsp_mirror_horizontal
);

   logic              in_valid_ff;
   logic              in_action_ff;
   logic [ADDR_W-1:0] in_address_ff;
   logic [DATA_W-1:0] in_data_ff;

   logic                  rsp_valid_ff;
   logic [ROM_ADDR_W-1:0] rsp_rom_address_ff;
   logic                  rsp_rom_selected_ff;
   logic                  rsp_write_taken_ff;
   logic                  rsp_chr_write_enable_ff;
   logic                  rsp_mirror_horizontal_ff;

   logic            out_ready;
   logic            advance;
   logic            taken;
   latch_state_type cur_state;
   latch_state_type new_state;
   latch_state_type eff_state;
   map_result_type  map_result;
   logic            chr_we;

   // Handshake: the output register frees when empty or being drained.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_action_ff  <= req_action;
         in_address_ff <= req_cpu_address;
         in_data_ff    <= req_write_data;
      end
   end

   // Decode a latch write and form the latch contents after this item.
   assign taken = in_valid_ff && in_action_ff == ACTION_WRITE &&
                  in_address_ff >= LATCH_BASE;
   assign new_state.mode = in_address_ff[MODE_W-1:0];
   assign new_state.bank = in_data_ff;
   assign eff_state      = taken ? new_state : cur_state;

   cmbm_latch u_latch (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (advance && taken),
      .wr_state (new_state),
      .state    (cur_state)
   );

   cmbm_map #(
      .PRG_ADDR_BITS (PRG_ADDR_BITS)
   ) u_map (
      .cpu_address (in_address_ff),
      .state       (eff_state),
      .result      (map_result)
   );

   // Pattern RAM is writable in the split, 8K and work RAM modes.
   assign chr_we = eff_state.mode == MODE_16K_SPLIT || eff_state.mode == MODE_8K_A ||
                   eff_state.mode == MODE_WRAM || eff_state.mode == MODE_8K_B;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rom_address_ff       <= map_result.rom_address;
         rsp_rom_selected_ff      <= map_result.selected;
         rsp_write_taken_ff       <= taken;
         rsp_chr_write_enable_ff  <= chr_we;
         rsp_mirror_horizontal_ff <= eff_state.bank[MIRROR_BIT];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rom_address       = rsp_rom_address_ff;
   assign rsp_rom_selected      = rsp_rom_selected_ff;
   assign rsp_write_taken       = rsp_write_taken_ff;
   assign rsp_chr_write_enable  = rsp_chr_write_enable_ff;
   assign rsp_mirror_horizontal = rsp_mirror_horizontal_ff;

   // A taken write shows up in the latch in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance && taken |=> cur_state.mode == $past(in_address_ff[MODE_W-1:0]) &&
                           cur_state.bank == $past(in_data_ff))
      else $error("latch did not load a taken write");

   // Without a taken write the latch holds.
   assert property (@(posedge clock) disable iff (reset)
      !(advance && taken) |=> $stable(cur_state))
      else $error("latch changed without a taken write");

   // A waiting response matches the latch it was computed from.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_mirror_horizontal_ff == cur_state.bank[MIRROR_BIT])
      else $error("mirroring out of step with the latch");

   // Unmapped accesses carry a zero ROM address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_rom_selected_ff |-> rsp_rom_address_ff == '0)
      else $error("nonzero address on an unmapped access");

endmodule

`default_nettype wire

// File: design/cmbm_latch.sv
`default_nettype none

module cmbm_latch
   import cmbm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire latch_state_type wr_state,
   output latch_state_type      state
);

   latch_state_type state_ff;
   latch_state_type state_in;

   // A taken write replaces mode and bank together.
   always_comb begin
      state_in = state_ff;
      if (wr_en) begin
         state_in = wr_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

// File: design/cmbm_map.sv
`default_nettype none

module cmbm_map
   import cmbm_pkg::*;
#(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT
)
(
   input  wire logic [ADDR_W-1:0] cpu_address,
   input  wire latch_state_type   state,
   output map_result_type         result
);

   localparam logic [ROM_ADDR_W-1:0] WRAP_MASK =
      ROM_ADDR_W'((64'd1 << PRG_ADDR_BITS) - 64'd1);

   logic [DATA_W-1:0]     d;
   logic [DATA_W:0]       e;
   logic [ROM_ADDR_W-1:0] addr;
   logic                  selected;

   // The 8K bank number is the bank byte with its top bit repeated below.
   assign d = state.bank;
   assign e = {d, d[DATA_W-1]};

   // Select the bank layout for the address window and the current mode.
   always_comb begin
      addr     = '0;
      selected = 1'b0;
      if (cpu_address >= ROM_BASE) begin
         selected = 1'b1;
         unique case (state.mode)
            MODE_32K_A, MODE_32K_B: begin
               addr = {d[7:1], cpu_address[14:0]};
            end
            MODE_16K_SPLIT: begin
               if (cpu_address < UPPER_BASE) begin
                  addr = {d, cpu_address[13:0]};
               end else begin
                  addr = {d[7:3], 3'b111, cpu_address[13:0]};
               end
            end
            MODE_8K_A, MODE_8K_B: begin
               addr = {e, cpu_address[12:0]};
            end
            MODE_16K_A, MODE_16K_B: begin
               addr = {d, cpu_address[13:0]};
            end
            MODE_WRAM: begin
               addr = {d[7:3], 2'b11, cpu_address[14:0]};
            end
            default: begin
               addr = '0;
            end
         endcase
      end else if (cpu_address >= WRAM_BASE && state.mode == MODE_WRAM) begin
         selected = 1'b1;
         addr     = {e, cpu_address[12:0]};
      end
   end

   // The ROM address wraps at the configured width.
   assign result.rom_address = addr & WRAP_MASK;
   assign result.selected    = selected;

endmodule

`default_nettype wire
